// ----- design/cbz_pkg.sv -----
`default_nettype none

package cbz_pkg;

  localparam int NUM_REGS = 4;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_POINT  = 3'd0,
    REG_START_HANDLE = 3'd1,
    REG_END_HANDLE   = 3'd2,
    REG_END_POINT    = 3'd3
  } reg_idx_t;

  // extra fraction bits carried through the horner chain
  localparam int GUARD_BITS = 8;

  // tangent components are scaled so the largest lands in [2^29, 2^30]
  localparam int NORM_BITS  = 30;
  localparam int MAG_W      = NORM_BITS + 1;
  localparam int SUM_W      = 2 * NORM_BITS + 2;
  localparam int ROOT_W     = SUM_W + 1;
  localparam int ROOT_CELLS = SUM_W / 2;

  // round half away from zero after an arithmetic right shift by s
  function automatic logic signed [63:0] rnd_haz(input logic signed [63:0] v,
                                                 input int unsigned s);
    logic [63:0] mag;
    logic [63:0] half;
    mag = v[63] ? 64'(-v) : 64'(v);
    if (s == 0) return v;
    half = 64'd1 << (s - 1);
    mag = (mag + half) >> s;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

`default_nettype wire

// ----- design/cbz_if.sv -----
`default_nettype none

interface cbz_in_if #(parameter int T_W = 18);
  logic                  valid;
  logic                  ready;
  logic signed [T_W-1:0] curve_param;
  modport source (output valid, curve_param, input ready);
  modport sink (input valid, curve_param, output ready);
endinterface

interface cbz_out_if #(parameter int COORD_W = 20, parameter int DIR_W = 16);
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic signed [DIR_W-1:0]   dir_x;
  logic signed [DIR_W-1:0]   dir_y;
  logic signed [DIR_W-1:0]   dir_z;
  modport source (output valid, point_x, point_y, point_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface cbz_cfg_if #(parameter int IDX_W = 3, parameter int DATA_W = 60);
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/cubic_bezier_point_and_tangent_core.sv -----
`default_nettype none

// channel  role    payload
// sample   sink    curve_param
// result   source  point_x/y/z, dir_x/y/z
// cfg      sink    index, data (always ready)
//
// one transaction per cycle sustained while result.ready holds; the path is 10 front
// stages, 31 square root cells, DIR_FRAC_BITS+1 divider cells and the output
// register
// reset clears the valid bits and the four control point registers
// a stage holds only while it is full and its neighbor holds, so bubbles close up

module cubic_bezier_point_and_tangent_core #(
  parameter int COORD_WIDTH   = 20,
  parameter int T_FRAC_BITS   = 16,
  parameter int DIR_FRAC_BITS = 14
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cbz_in_if.sink     sample,
  cbz_out_if.source  result,
  cbz_cfg_if.sink    cfg
);
  import cbz_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int REG_W  = 3 * CW;
  localparam int T_W    = T_FRAC_BITS + 2;
  localparam int TU_W   = T_FRAC_BITS + 1;
  localparam int DIR_W  = DIR_FRAC_BITS + 2;
  localparam int E_W    = CW + 1;
  localparam int CO_W   = CW + 6;
  localparam int R_W    = CW + GUARD_BITS + 8;
  localparam int M_W    = R_W + TU_W + 1;
  localparam int SQ_W   = 2 * TU_W;
  localparam int WSH    = (2 * T_FRAC_BITS > NORM_BITS) ? 2 * T_FRAC_BITS - NORM_BITS : 0;
  localparam int WW     = MAG_W;
  localparam int PR_W   = WW + E_W + 1;
  localparam int D_W    = PR_W + 2;
  localparam int BL_W   = $clog2(D_W + 1);
  localparam int QB     = DIR_FRAC_BITS + 1;
  localparam int NUM_W  = DIR_FRAC_BITS + MAG_W + 1;
  localparam int PT_SH  = T_FRAC_BITS + GUARD_BITS;
  localparam int SIDE_R = 4 + 3 * MAG_W + 3 * CW;
  localparam int SIDE_D = 4 + 3 * CW;
  localparam int NFRONT = 10;

  localparam logic [TU_W-1:0]         ONE_T   = TU_W'(1) << T_FRAC_BITS;
  localparam logic signed [63:0]      CMAX    = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0]      CMIN    = -CMAX - 64'sd1;
  localparam logic [QB-1:0]           DLIM    = QB'(1) << DIR_FRAC_BITS;
  localparam logic signed [DIR_W-1:0] DIR_MAX = DIR_W'(DLIM);

  // ---------------- configuration ----------------
  logic [REG_W-1:0] reg_p0, reg_p1, reg_p2, reg_p3;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_p0 <= '0;
      reg_p1 <= '0;
      reg_p2 <= '0;
      reg_p3 <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_START_POINT:  reg_p0 <= cfg.data;
        REG_START_HANDLE: reg_p1 <= cfg.data;
        REG_END_HANDLE:   reg_p2 <= cfg.data;
        REG_END_POINT:    reg_p3 <= cfg.data;
        default: ;
      endcase
    end
  end

  // polynomial coefficients and control point differences
  logic signed [CW-1:0]   pc0 [3];
  logic signed [CW-1:0]   pc1 [3];
  logic signed [CW-1:0]   pc2 [3];
  logic signed [CW-1:0]   pc3 [3];
  logic signed [E_W-1:0]  de  [3][3];
  logic signed [CO_W-1:0] dc  [3];
  logic signed [CO_W-1:0] db  [3];
  logic signed [CO_W-1:0] da  [3];
  logic signed [E_W-1:0]  co_e  [3][3];
  logic signed [CO_W-1:0] co_a  [3];
  logic signed [CO_W-1:0] co_b  [3];
  logic signed [CO_W-1:0] co_c  [3];
  logic signed [CW-1:0]   co_p0 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pc0[k] = $signed(reg_p0[k*CW +: CW]);
      pc1[k] = $signed(reg_p1[k*CW +: CW]);
      pc2[k] = $signed(reg_p2[k*CW +: CW]);
      pc3[k] = $signed(reg_p3[k*CW +: CW]);
      de[0][k] = E_W'(pc1[k]) - E_W'(pc0[k]);
      de[1][k] = E_W'(pc2[k]) - E_W'(pc1[k]);
      de[2][k] = E_W'(pc3[k]) - E_W'(pc2[k]);
      dc[k] = (CO_W'(de[0][k]) <<< 1) + CO_W'(de[0][k]);
      db[k] = (CO_W'(de[1][k]) <<< 1) + CO_W'(de[1][k]) - dc[k];
      da[k] = CO_W'(de[0][k]) + CO_W'(de[1][k]) + CO_W'(de[2][k]) - dc[k] - db[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      co_a[k]  <= da[k];
      co_b[k]  <= db[k];
      co_c[k]  <= dc[k];
      co_p0[k] <= pc0[k];
      for (int j = 0; j < 3; j++) begin
        co_e[j][k] <= de[j][k];
      end
    end
  end

  // ---------------- front stages ----------------
  logic [NFRONT-1:0] fv;
  logic [NFRONT-1:0] frdy;
  logic              root_in_ready;

  always_comb begin
    frdy[NFRONT-1] = !fv[NFRONT-1] || root_in_ready;
    for (int i = NFRONT - 2; i >= 0; i--) begin
      frdy[i] = !fv[i] || frdy[i+1];
    end
  end

  assign sample.ready = frdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else begin
      if (frdy[0]) fv[0] <= sample.valid;
      for (int i = 1; i < NFRONT; i++) begin
        if (frdy[i]) fv[i] <= fv[i-1];
      end
    end
  end

  logic [TU_W-1:0]          s0_t, s0_u;
  logic [TU_W-1:0]          s1_t;
  logic signed [M_W-1:0]    s1_m [3];
  logic [SQ_W-1:0]          s1_uu, s1_tu, s1_tt;
  logic [TU_W-1:0]          s2_t;
  logic signed [R_W-1:0]    s2_r [3];
  logic [WW-1:0]            s2_w [3];
  logic [TU_W-1:0]          s3_t;
  logic signed [M_W-1:0]    s3_m [3];
  logic signed [PR_W-1:0]   s3_pr [3][3];
  logic [TU_W-1:0]          s4_t;
  logic signed [R_W-1:0]    s4_r [3];
  logic signed [D_W-1:0]    s4_d [3];
  logic signed [M_W-1:0]    s5_m [3];
  logic [2:0][D_W-1:0]      s5_mag;
  logic [2:0]               s5_sg;
  logic [D_W-1:0]           s5_max;
  logic [2:0][CW-1:0]       s6_pt;
  logic [2:0][D_W-1:0]      s6_mag;
  logic [2:0]               s6_sg;
  logic [BL_W-1:0]          s6_bl;
  logic                     s6_zero;
  logic [2:0][CW-1:0]       s7_pt, s8_pt, s9_pt;
  logic [2:0][MAG_W-1:0]    s7_mag, s8_mag, s9_mag;
  logic [2:0]               s7_sg, s8_sg, s9_sg;
  logic                     s7_zero, s8_zero, s9_zero;
  logic [SUM_W-1:0]         s8_sq [3];
  logic [SUM_W-1:0]         s9_sum;

  logic [TU_W-1:0]          t_clamp;
  logic [2:0][D_W-1:0]      mag_n;
  logic [D_W-1:0]           max_n;
  logic [2:0][CW-1:0]       pt_n;
  logic signed [63:0]       pv [3];
  logic [BL_W-1:0]          bl_n;
  logic signed [63:0]       nrm [3];
  logic [2:0][MAG_W-1:0]    norm_n;

  // clamp t to 0..1
  always_comb begin
    if (sample.curve_param[T_W-1]) begin
      t_clamp = '0;
    end else if (sample.curve_param[T_W-2:0] > ONE_T) begin
      t_clamp = ONE_T;
    end else begin
      t_clamp = sample.curve_param[T_W-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (frdy[0]) begin
      s0_t <= t_clamp;
      s0_u <= ONE_T - t_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (frdy[1]) begin
      s1_t  <= s0_t;
      s1_uu <= SQ_W'(s0_u) * SQ_W'(s0_u);
      s1_tu <= (SQ_W'(s0_t) * SQ_W'(s0_u)) << 1;
      s1_tt <= SQ_W'(s0_t) * SQ_W'(s0_t);
      for (int k = 0; k < 3; k++) begin
        s1_m[k] <= M_W'(co_a[k]) * M_W'($signed({1'b0, s0_t}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frdy[2]) begin
      s2_t    <= s1_t;
      s2_w[0] <= WW'(rnd_haz(64'(s1_uu), WSH));
      s2_w[1] <= WW'(rnd_haz(64'(s1_tu), WSH));
      s2_w[2] <= WW'(rnd_haz(64'(s1_tt), WSH));
      for (int k = 0; k < 3; k++) begin
        s2_r[k] <= R_W'(rnd_haz((64'(s1_m[k]) + (64'(co_b[k]) <<< T_FRAC_BITS))
                                <<< GUARD_BITS, T_FRAC_BITS));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frdy[3]) begin
      s3_t <= s2_t;
      for (int k = 0; k < 3; k++) begin
        s3_m[k] <= M_W'(s2_r[k]) * M_W'($signed({1'b0, s2_t}));
        for (int j = 0; j < 3; j++) begin
          s3_pr[k][j] <= PR_W'($signed({1'b0, s2_w[j]})) * PR_W'(co_e[j][k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frdy[4]) begin
      s4_t <= s3_t;
      for (int k = 0; k < 3; k++) begin
        s4_r[k] <= R_W'(rnd_haz(64'(s3_m[k]) + (64'(co_c[k]) <<< PT_SH), T_FRAC_BITS));
        s4_d[k] <= D_W'(s3_pr[k][0]) + D_W'(s3_pr[k][1]) + D_W'(s3_pr[k][2]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_n[k] = s4_d[k][D_W-1] ? D_W'(-s4_d[k]) : D_W'(s4_d[k]);
    end
    max_n = (mag_n[0] > mag_n[1]) ? mag_n[0] : mag_n[1];
    if (mag_n[2] > max_n) max_n = mag_n[2];
  end

  always_ff @(posedge clk) begin
    if (frdy[5]) begin
      s5_mag <= mag_n;
      s5_max <= max_n;
      for (int k = 0; k < 3; k++) begin
        s5_m[k]  <= M_W'(s4_r[k]) * M_W'($signed({1'b0, s4_t}));
        s5_sg[k] <= s4_d[k][D_W-1];
      end
    end
  end

  // final horner step with saturation, and the bit length of the largest component
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pv[k] = rnd_haz(64'(s5_m[k]) + (64'(co_p0[k]) <<< PT_SH), PT_SH);
      if (pv[k] > CMAX) begin
        pt_n[k] = CW'(CMAX);
      end else if (pv[k] < CMIN) begin
        pt_n[k] = CW'(CMIN);
      end else begin
        pt_n[k] = CW'(pv[k]);
      end
    end
    bl_n = '0;
    for (int i = 0; i < D_W; i++) begin
      if (s5_max[i]) bl_n = BL_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (frdy[6]) begin
      s6_pt   <= pt_n;
      s6_mag  <= s5_mag;
      s6_sg   <= s5_sg;
      s6_bl   <= bl_n;
      s6_zero <= (s5_max == '0);
    end
  end

  // scale so the largest component lands in [2^29, 2^30]
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s6_bl > BL_W'(NORM_BITS)) begin
        nrm[k] = rnd_haz(64'(s6_mag[k]), int'(s6_bl) - NORM_BITS);
      end else begin
        nrm[k] = 64'(s6_mag[k]) << (NORM_BITS - int'(s6_bl));
      end
      norm_n[k] = MAG_W'(nrm[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (frdy[7]) begin
      s7_pt   <= s6_pt;
      s7_mag  <= norm_n;
      s7_sg   <= s6_sg;
      s7_zero <= s6_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (frdy[8]) begin
      s8_pt   <= s7_pt;
      s8_mag  <= s7_mag;
      s8_sg   <= s7_sg;
      s8_zero <= s7_zero;
      for (int k = 0; k < 3; k++) begin
        s8_sq[k] <= SUM_W'(s7_mag[k]) * SUM_W'(s7_mag[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frdy[9]) begin
      s9_pt   <= s8_pt;
      s9_mag  <= s8_mag;
      s9_sg   <= s8_sg;
      s9_zero <= s8_zero;
      s9_sum  <= s8_sq[0] + s8_sq[1] + s8_sq[2];
    end
  end

  // ---------------- square root cell row ----------------
  logic              rt_valid [ROOT_CELLS+1];
  logic              rt_ready [ROOT_CELLS+1];
  logic [SUM_W-1:0]  rt_x     [ROOT_CELLS+1];
  logic [ROOT_W-1:0] rt_r     [ROOT_CELLS+1];
  logic [SIDE_R-1:0] rt_side  [ROOT_CELLS+1];

  assign rt_valid[0]   = fv[NFRONT-1];
  assign root_in_ready = rt_ready[0];
  assign rt_x[0]       = s9_sum;
  assign rt_r[0]       = '0;
  assign rt_side[0]    = {s9_zero, s9_sg, s9_mag, s9_pt};

  for (genvar i = 0; i < ROOT_CELLS; i++) begin : g_root
    cbz_root_cell #(
      .K      (ROOT_CELLS - 1 - i),
      .SIDE_W (SIDE_R)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (rt_valid[i]),
      .up_ready (rt_ready[i]),
      .up_x     (rt_x[i]),
      .up_r     (rt_r[i]),
      .up_side  (rt_side[i]),
      .dn_valid (rt_valid[i+1]),
      .dn_ready (rt_ready[i+1]),
      .dn_x     (rt_x[i+1]),
      .dn_r     (rt_r[i+1]),
      .dn_side  (rt_side[i+1])
    );
  end

  // ---------------- divider cell row ----------------
  logic                  rz;
  logic [2:0]            rsg;
  logic [2:0][MAG_W-1:0] rmag;
  logic [2:0][CW-1:0]    rpt;
  logic [MAG_W-1:0]      rnorm;

  logic                  dv_valid [QB+1];
  logic                  dv_ready [QB+1];
  logic [2:0][NUM_W-1:0] dv_rem   [QB+1];
  logic [2:0][QB-1:0]    dv_q     [QB+1];
  logic [MAG_W-1:0]      dv_norm  [QB+1];
  logic [SIDE_D-1:0]     dv_side  [QB+1];

  assign {rz, rsg, rmag, rpt} = rt_side[ROOT_CELLS];
  assign rnorm                = rt_r[ROOT_CELLS][MAG_W-1:0];
  assign dv_valid[0]          = rt_valid[ROOT_CELLS];
  assign rt_ready[ROOT_CELLS] = dv_ready[0];
  assign dv_norm[0]           = rnorm;
  assign dv_q[0]              = '0;
  assign dv_side[0]           = {rz, rsg, rpt};

  // numerator carries the half divisor for round to nearest
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv_rem[0][k] = (NUM_W'(rmag[k]) << DIR_FRAC_BITS) + NUM_W'(rnorm >> 1);
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    cbz_div_cell #(
      .J      (QB - 1 - i),
      .NUM_W  (NUM_W),
      .QB     (QB),
      .SIDE_W (SIDE_D)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (dv_valid[i]),
      .up_ready (dv_ready[i]),
      .up_rem   (dv_rem[i]),
      .up_q     (dv_q[i]),
      .up_norm  (dv_norm[i]),
      .up_side  (dv_side[i]),
      .dn_valid (dv_valid[i+1]),
      .dn_ready (dv_ready[i+1]),
      .dn_rem   (dv_rem[i+1]),
      .dn_q     (dv_q[i+1]),
      .dn_norm  (dv_norm[i+1]),
      .dn_side  (dv_side[i+1])
    );
  end

  // ---------------- output register ----------------
  logic                    oz;
  logic [2:0]              osg;
  logic [2:0][CW-1:0]      opt;
  logic [QB-1:0]           qc   [3];
  logic signed [DIR_W-1:0] dir_n [3];
  logic                    out_load;

  assign {oz, osg, opt} = dv_side[QB];
  assign out_load       = !result.valid || result.ready;
  assign dv_ready[QB]   = out_load;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k] = (dv_q[QB][k] > DLIM) ? DLIM : dv_q[QB][k];
      if (oz) begin
        dir_n[k] = '0;
      end else if (osg[k]) begin
        dir_n[k] = -$signed(DIR_W'(qc[k]));
      end else begin
        dir_n[k] = $signed(DIR_W'(qc[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= dv_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.point_x <= $signed(opt[0]);
      result.point_y <= $signed(opt[1]);
      result.point_z <= $signed(opt[2]);
      result.dir_x   <= dir_n[0];
      result.dir_y   <= dir_n[1];
      result.dir_z   <= dir_n[2];
    end
  end

`ifndef ASSERT_OFF
  a_cfg_unknown_ignored: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && (cfg.index >= REG_IDX_W'(NUM_REGS))
    |=> $stable({reg_p0, reg_p1, reg_p2, reg_p3}))
    else $error("write to unknown register index changed a control point");

  a_norm_floor: assert property (@(posedge clk) disable iff (rst)
    rt_valid[ROOT_CELLS] && !rz |-> rnorm >= (MAG_W'(1) << (NORM_BITS - 1)))
    else $error("square root of a nonzero tangent below the scaled floor");

  a_dir_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.dir_x <= DIR_MAX) && (result.dir_x >= -DIR_MAX)
                  && (result.dir_y <= DIR_MAX) && (result.dir_y >= -DIR_MAX)
                  && (result.dir_z <= DIR_MAX) && (result.dir_z >= -DIR_MAX))
    else $error("tangent component outside unit range");
`endif

endmodule

`default_nettype wire

// ----- design/cbz_root_cell.sv -----
`default_nettype none

module cbz_root_cell #(
  parameter int K      = 0,
  parameter int SIDE_W = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       up_valid,
  output logic                            up_ready,
  input  wire logic [cbz_pkg::SUM_W-1:0]  up_x,
  input  wire logic [cbz_pkg::ROOT_W-1:0] up_r,
  input  wire logic [SIDE_W-1:0]          up_side,
  output logic                            dn_valid,
  input  wire logic                       dn_ready,
  output logic [cbz_pkg::SUM_W-1:0]       dn_x,
  output logic [cbz_pkg::ROOT_W-1:0]      dn_r,
  output logic [SIDE_W-1:0]               dn_side
);
  import cbz_pkg::*;

  localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * K);

  logic [ROOT_W-1:0] trial;
  logic              fire;
  logic [SUM_W-1:0]  x_next;
  logic [ROOT_W-1:0] r_next;

  // one digit of the bitwise square root
  always_comb begin
    trial  = up_r + BIT;
    fire   = {1'b0, up_x} >= trial;
    x_next = fire ? up_x - trial[SUM_W-1:0] : up_x;
    r_next = fire ? (up_r >> 1) + BIT : up_r >> 1;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_x    <= x_next;
      dn_r    <= r_next;
      dn_side <= up_side;
    end
  end

endmodule

`default_nettype wire

// ----- design/cbz_div_cell.sv -----
`default_nettype none

module cbz_div_cell #(
  parameter int J      = 0,
  parameter int NUM_W  = 46,
  parameter int QB     = 15,
  parameter int SIDE_W = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      up_valid,
  output logic                           up_ready,
  input  wire logic [2:0][NUM_W-1:0]     up_rem,
  input  wire logic [2:0][QB-1:0]        up_q,
  input  wire logic [cbz_pkg::MAG_W-1:0] up_norm,
  input  wire logic [SIDE_W-1:0]         up_side,
  output logic                           dn_valid,
  input  wire logic                      dn_ready,
  output logic [2:0][NUM_W-1:0]          dn_rem,
  output logic [2:0][QB-1:0]             dn_q,
  output logic [cbz_pkg::MAG_W-1:0]      dn_norm,
  output logic [SIDE_W-1:0]              dn_side
);
  import cbz_pkg::*;

  logic [NUM_W-1:0]       dsh;
  logic [2:0][NUM_W-1:0]  rem_next;
  logic [2:0][QB-1:0]     q_next;

  // one quotient bit for each of the three lanes
  always_comb begin
    dsh = NUM_W'(up_norm) << J;
    for (int l = 0; l < 3; l++) begin
      if (up_rem[l] >= dsh) begin
        rem_next[l] = up_rem[l] - dsh;
        q_next[l]   = up_q[l] | (QB'(1) << J);
      end else begin
        rem_next[l] = up_rem[l];
        q_next[l]   = up_q[l];
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_rem  <= rem_next;
      dn_q    <= q_next;
      dn_norm <= up_norm;
      dn_side <= up_side;
    end
  end

endmodule

`default_nettype wire

// ----- tb/cubic_bezier_point_and_tangent_checker.sv -----
module cubic_bezier_point_and_tangent_checker (
  input  logic clk,
  input  logic rst,
  cbz_in_if    sample,
  cbz_out_if   result,
  cbz_cfg_if   cfg,
  output int   fails,
  output int   pending
);
  import cbz_pkg::*;

  typedef struct {
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [19:0] pz;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
  } curve_sample_t;

  logic [59:0]   ctrl_pts [NUM_REGS];
  curve_sample_t curve_q [$];

  function automatic longint round_away(longint v, int s);
    longint unsigned mag;
    if (s == 0) return v;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic curve_sample_t eval_curve(logic [17:0] tin);
    curve_sample_t res;
    longint t, u, w0, w1, w2, c, b, a, r, pt, m, maxmag, mm;
    longint p [4];
    longint d [3];
    longint pnt [3];
    longint q [3];
    longint unsigned sum, norm, mag;
    int sh;
    t = longint'($signed(tin));
    if (t < 0) t = 0;
    if (t > 65536) t = 65536;
    u = 65536 - t;
    w0 = round_away(u * u, 2);
    w1 = round_away(2 * t * u, 2);
    w2 = round_away(t * t, 2);
    maxmag = 0;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 4; i++) p[i] = longint'($signed(ctrl_pts[i][k*20 +: 20]));
      c = 3 * (p[1] - p[0]);
      b = 3 * (p[2] - p[1]) - c;
      a = p[3] - p[0] - c - b;
      r = round_away(a * 256 * t + b * 256 * 65536, 16);
      r = round_away(r * t + c * 256 * 65536, 16);
      pt = round_away(r * t + p[0] * 256 * 65536, 24);
      if (pt > 524287) pt = 524287;
      if (pt < -524288) pt = -524288;
      pnt[k] = pt;
      d[k] = w0 * (p[1] - p[0]) + w1 * (p[2] - p[1]) + w2 * (p[3] - p[2]);
      m = (d[k] < 0) ? -d[k] : d[k];
      if (m > maxmag) maxmag = m;
    end
    for (int k = 0; k < 3; k++) q[k] = 0;
    if (maxmag != 0) begin
      sh = 0;
      mm = maxmag;
      while (mm >= (64'd1 << 30)) begin
        mm = mm >>> 1;
        sh++;
      end
      for (int k = 0; k < 3; k++) d[k] = round_away(d[k], sh);
      // small vectors are brought up so the root keeps its precision
      while (mm < (64'd1 << 29)) begin
        mm = mm * 2;
        for (int k = 0; k < 3; k++) d[k] = d[k] * 2;
      end
      sum = 0;
      for (int k = 0; k < 3; k++) sum = sum + longint'(d[k] * d[k]);
      norm = floor_root(sum);
      for (int k = 0; k < 3; k++) begin
        mag = (d[k] < 0) ? -d[k] : d[k];
        if (norm != 0) begin
          mag = ((mag << 14) + (norm >> 1)) / norm;
          if (mag > 16384) mag = 16384;
          q[k] = (d[k] < 0) ? -longint'(mag) : longint'(mag);
        end
      end
    end
    res.px = pnt[0][19:0];
    res.py = pnt[1][19:0];
    res.pz = pnt[2][19:0];
    res.dx = q[0][15:0];
    res.dy = q[1][15:0];
    res.dz = q[2][15:0];
    return res;
  endfunction

  task automatic check_field(string name, longint expd, longint got);
    if (expd != got) begin
      $error("%s: expected %0d, actual %0d", name, expd, got);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    curve_sample_t e;
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) ctrl_pts[i] <= '0;
    end else begin
      if (cfg.valid && cfg.ready && cfg.index < NUM_REGS) ctrl_pts[cfg.index] <= cfg.data;
      if (sample.valid && sample.ready) curve_q.push_back(eval_curve(sample.curve_param));
      if (result.valid && result.ready) begin
        if (curve_q.size() == 0) begin
          $error("result transaction with no sample outstanding");
          fails++;
        end else begin
          e = curve_q.pop_front();
          check_field("point_x", e.px, result.point_x);
          check_field("point_y", e.py, result.point_y);
          check_field("point_z", e.pz, result.point_z);
          check_field("dir_x", e.dx, result.dir_x);
          check_field("dir_y", e.dy, result.dir_y);
          check_field("dir_z", e.dz, result.dir_z);
        end
      end
      pending <= curve_q.size();
    end
  end
endmodule

// ----- tb/cubic_bezier_point_and_tangent_core_test.sv -----
module cubic_bezier_point_and_tangent_core_test;
  import cbz_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   cycles;

  cbz_in_if  #(.T_W(18)) sample_ch ();
  cbz_out_if #(.COORD_W(20), .DIR_W(16)) result_ch ();
  cbz_cfg_if #(.IDX_W(3), .DATA_W(60)) cfg_ch ();

  cubic_bezier_point_and_tangent_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  cubic_bezier_point_and_tangent_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .cfg     (cfg_ch),
    .fails   (fails),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    result_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(logic [2:0] idx, logic [59:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    forever begin
      @(negedge clk);
      if (cfg_ch.ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_param(logic [17:0] tval);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.curve_param <= tval;
    forever begin
      @(negedge clk);
      if (sample_ch.ready) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // hold the sample channel until every result is back, then let the pipe empty
  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  function automatic logic [19:0] pick_coord(int mode);
    case (mode)
      0:       return 20'($signed($urandom_range(16)) - 8);
      1:       return 20'($urandom);
      2:       return $urandom_range(1) ? 20'h7ffff : 20'h80000;
      default: return 20'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  function automatic logic [59:0] pick_point(int mode);
    return {pick_coord(mode), pick_coord(mode), pick_coord(mode)};
  endfunction

  task automatic load_curve(logic [59:0] p0, logic [59:0] p1, logic [59:0] p2,
                            logic [59:0] p3);
    write_reg(REG_START_POINT, p0);
    write_reg(REG_START_HANDLE, p1);
    write_reg(REG_END_HANDLE, p2);
    write_reg(REG_END_POINT, p3);
  endtask

  task automatic random_curve();
    int mode;
    mode = $urandom_range(3);
    load_curve(pick_point(mode), pick_point(mode), pick_point(mode), pick_point(mode));
    // stray write to an index past the last register
    if ($urandom_range(3) == 0) write_reg(3'($urandom_range(7, 4)), 60'({$urandom, $urandom}));
  endtask

  function automatic logic [17:0] pick_param();
    int sel;
    sel = $urandom_range(9);
    if (sel < 7) return 18'($urandom_range(65536));
    if (sel == 7) return 18'($urandom);
    if (sel == 8) return 18'($urandom_range(65540, 65530));
    return 18'($urandom_range(3));
  endfunction

  initial begin
    int idle_s [3];
    int idle_r [3];
    idle_s = '{36, 80, 0};
    idle_r = '{80, 36, 0};
    rst = 1'b1;
    send_idle_pct = 36;
    recv_idle_pct = 80;
    sample_ch.valid       = 1'b0;
    sample_ch.curve_param = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all control points zero after reset: zero derivative, t clamped both ways
    send_param(18'h20000);
    send_param(18'h1ffff);
    send_param(18'd0);
    send_param(18'd65536);
    drain();

    // extreme corners put the point at the ends of its range
    load_curve({3{20'h7ffff}}, {3{20'h80000}}, {3{20'h7ffff}}, {3{20'h80000}});
    send_param(18'd0);
    send_param(18'd1);
    send_param(18'd32768);
    send_param(18'd65535);
    send_param(18'd65536);
    send_param(18'h20000);
    drain();

    // coincident first handle: tangent vanishes at t = 0
    load_curve({3{20'd100}}, {3{20'd100}}, {20'd5, 20'h80000, 20'h7ffff}, {3{20'd900}});
    send_param(18'd0);
    send_param(18'd16384);
    send_param(18'd49152);
    drain();

    // tiny derivative gets scaled up before the root; stray index is ignored
    load_curve(60'd0, {20'd0, 20'd0, 20'd1}, {20'd0, 20'd1, 20'd1}, {20'd1, 20'd1, 20'd1});
    write_reg(3'd7, '1);
    write_reg(3'd4, '1);
    send_param(18'd0);
    send_param(18'd32768);
    send_param(18'd65536);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = idle_s[ph];
      recv_idle_pct = idle_r[ph];
      for (int n = 0; n < 4; n++) begin
        random_curve();
        for (int i = 0; i < 100; i++) send_param(pick_param());
        drain();
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
design/cbz_pkg.sv
design/cbz_if.sv
design/cbz_root_cell.sv
design/cbz_div_cell.sv
design/cubic_bezier_point_and_tangent_core.sv
tb/cubic_bezier_point_and_tangent_checker.sv
tb/cubic_bezier_point_and_tangent_core_test.sv
